// ===== sv/tgod_pkg.sv =====
`default_nettype none

package tgod_pkg;

    // Coordinate width of every tile and gate end field.
    localparam int COORD_BITS = 12;

    // Signed width that holds every offset, bound and four-term sum of the geometry.
    localparam int GEO_W = COORD_BITS + 3;

    // Fixed point format of the distance and of the diagonal surcharge.
    localparam int FRAC_BITS    = 8;
    localparam int DIAG_EXTRA_W = 8;
    localparam int DIST_W       = 21;

    localparam logic [DIAG_EXTRA_W-1:0] DIAG_EXTRA_RESET = DIAG_EXTRA_W'(106);
    localparam logic [DIST_W-1:0]       DIST_MAX         = {DIST_W{1'b1}};

    // Stream data widths, padded up to whole bytes.
    localparam int S_TDATA_W = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DIST_W + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord tile_x;
        t_coord tile_y;
        t_coord gate_start_x;
        t_coord gate_start_y;
        t_coord gate_end_x;
        t_coord gate_end_y;
    } t_item;

    // Larger and smaller magnitude of the two offsets to the gate.
    typedef struct packed {
        t_coord big;
        t_coord small_mag;
    } t_span;

endpackage

`default_nettype wire

// ===== sv/tgod_offsets.sv =====
`default_nettype none

module tgod_offsets (
    input  wire tgod_pkg::t_item i_item,
    output tgod_pkg::t_span      o_span
);

    localparam int W = tgod_pkg::GEO_W;
    localparam int C = tgod_pkg::COORD_BITS;

    logic signed [W-1:0] w_tx, w_ty, w_sx, w_sy, w_ex, w_ey;
    logic signed [W-1:0] w_lx, w_hx, w_ly, w_hy;
    logic signed [W-1:0] w_dx, w_dy, w_sum, w_mid;
    logic                w_backslash;
    logic [C-1:0]        w_ax, w_ay;

    // Zero extend every coordinate into the signed working width.
    assign w_tx = $signed({{(W-C){1'b0}}, i_item.tile_x});
    assign w_ty = $signed({{(W-C){1'b0}}, i_item.tile_y});
    assign w_sx = $signed({{(W-C){1'b0}}, i_item.gate_start_x});
    assign w_sy = $signed({{(W-C){1'b0}}, i_item.gate_start_y});
    assign w_ex = $signed({{(W-C){1'b0}}, i_item.gate_end_x});
    assign w_ey = $signed({{(W-C){1'b0}}, i_item.gate_end_y});

    assign w_lx = (w_sx < w_ex) ? w_sx : w_ex;
    assign w_hx = (w_sx < w_ex) ? w_ex : w_sx;
    assign w_ly = (w_sy < w_ey) ? w_sy : w_ey;
    assign w_hy = (w_sy < w_ey) ? w_ey : w_sy;

    // A backslash gate has y falling while x rises.
    assign w_backslash = (w_sy > w_ey) ? (w_sx <= w_ex) : (w_sx > w_ex);

    // Four-difference sum of the middle region, then divided by four toward zero.
    assign w_sum = w_backslash
                 ? (w_tx - w_lx) + (w_tx - w_hx) + (w_ty - w_ly) + (w_ty - w_hy)
                 : (w_tx - w_lx) + (w_tx - w_hx) + (w_ly - w_ty) + (w_hy - w_ty);
    assign w_mid = w_sum[W-1] ? ((w_sum + $signed(W'(3))) >>> 2) : (w_sum >>> 2);

    always_comb begin
        w_dx = '0;
        w_dy = '0;
        if (w_sx == w_ex) begin
            // Vertical gate, which also covers a gate of a single tile.
            if (w_ty > w_hy) begin
                w_dy = w_ty - w_hy;
            end else if (w_ty < w_ly) begin
                w_dy = w_ly - w_ty;
            end
            w_dx = w_tx - w_sx;
        end else if (w_sy == w_ey) begin
            if (w_tx > w_hx) begin
                w_dx = w_tx - w_hx;
            end else if (w_tx < w_lx) begin
                w_dx = w_lx - w_tx;
            end
            w_dy = w_ty - w_sy;
        end else if (w_backslash) begin
            if (w_ty > w_hy - (w_lx - w_tx)) begin
                w_dx = w_tx - w_lx;
                w_dy = w_ty - w_hy;
            end else if (w_ty < w_ly - (w_hx - w_tx)) begin
                w_dx = w_hx - w_tx;
                w_dy = w_ly - w_ty;
            end else begin
                w_dx = w_mid;
                w_dy = w_mid;
            end
        end else begin
            if (w_ty > w_hy - (w_tx - w_hx)) begin
                w_dx = w_tx - w_hx;
                w_dy = w_ty - w_hy;
            end else if (w_ty < w_ly - (w_tx - w_lx)) begin
                w_dx = w_lx - w_tx;
                w_dy = w_ly - w_ty;
            end else begin
                w_dx = w_mid;
                w_dy = w_mid;
            end
        end
    end

    // Every offset magnitude stays below 2^COORD_BITS, so the low bits carry it.
    assign w_ax = w_dx[W-1] ? C'(-w_dx) : C'(w_dx);
    assign w_ay = w_dy[W-1] ? C'(-w_dy) : C'(w_dy);

    always_comb begin
        if (w_ax[C-1:0] > w_ay[C-1:0]) begin
            o_span.big       = w_ax[C-1:0];
            o_span.small_mag = w_ay[C-1:0];
        end else begin
            o_span.big       = w_ay[C-1:0];
            o_span.small_mag = w_ax[C-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tile_to_gate_octile_distance.sv =====
`default_nettype none

// Tile-to-gate octile distance. Each request on the slave stream carries a tile
// and the two end tiles of a gate; the block classifies the gate as vertical,
// horizontal or 45-degree diagonal (anything else is handled as diagonal), finds
// the x and y offsets from the tile to the nearest part of the gate, and returns
// max(|dx|,|dy|) + diagonal_extra * min(|dx|,|dy|) in unsigned Q.8 on the master
// stream, saturated at the top of the 21-bit field. One request is taken every
// clock cycle when the master side keeps up. On its way to the master stream
// each request passes an input register (loaded at the edge that accepts it), a
// register after the gate geometry, and the result register behind the
// surcharge multiply-add.
// Stages hold their contents when the master stalls, and a stage that is empty
// or moving on takes new data, so the ready path runs combinationally from
// m_axis_tready back to s_axis_tready. The surcharge register is written through
// its own channel, which is always ready; write it only while no request is in
// flight.
module tile_to_gate_octile_distance (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    // Slave stream. tdata from bit 0 up: tile_x, tile_y, gate_start_x,
    // gate_start_y, gate_end_x, gate_end_y, each COORD_BITS wide.
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [tgod_pkg::S_TDATA_W-1:0]     s_axis_tdata,

    // Master stream. tdata from bit 0 up: distance (21 bits), then zero padding.
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [tgod_pkg::M_TDATA_W-1:0]     m_axis_tdata,

    // Surcharge write channel: diagonal_extra, Q0.8.
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [tgod_pkg::DIAG_EXTRA_W-1:0]  i_cfg_data
);

    localparam int C      = tgod_pkg::COORD_BITS;
    localparam int PROD_W = C + tgod_pkg::DIAG_EXTRA_W;
    // Wide enough for the full sum and for a saturation compare at any COORD_BITS.
    localparam int CALC_W = (C + tgod_pkg::FRAC_BITS + 1 > tgod_pkg::DIST_W + 1)
                          ? C + tgod_pkg::FRAC_BITS + 1 : tgod_pkg::DIST_W + 1;

    logic                              r_v1, r_v2, r_v3;
    logic                              w_rdy1, w_rdy2, w_rdy3;
    tgod_pkg::t_item                   r_item;
    tgod_pkg::t_span                   w_span, r_span;
    logic [tgod_pkg::DIAG_EXTRA_W-1:0] r_diag_extra;
    logic [PROD_W-1:0]                 w_prod;
    logic [CALC_W-1:0]                 w_sum;
    logic [tgod_pkg::DIST_W-1:0]       n_dist, r_dist;

    // A stage accepts when it is empty or when its content moves on this cycle.
    assign w_rdy3 = !r_v3 || m_axis_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign s_axis_tready = w_rdy1;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(tgod_pkg::M_TDATA_W - tgod_pkg::DIST_W){1'b0}}, r_dist};
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_diag_extra <= tgod_pkg::DIAG_EXTRA_RESET;
        end else begin
            if (w_rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_diag_extra <= i_cfg_data;
            end
        end
    end

    // Data registers load only when their stage takes a valid request.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && w_rdy1) begin
            r_item.tile_x       <= s_axis_tdata[0*C +: C];
            r_item.tile_y       <= s_axis_tdata[1*C +: C];
            r_item.gate_start_x <= s_axis_tdata[2*C +: C];
            r_item.gate_start_y <= s_axis_tdata[3*C +: C];
            r_item.gate_end_x   <= s_axis_tdata[4*C +: C];
            r_item.gate_end_y   <= s_axis_tdata[5*C +: C];
        end
        if (r_v1 && w_rdy2) begin
            r_span <= w_span;
        end
        if (r_v2 && w_rdy3) begin
            r_dist <= n_dist;
        end
    end

    // Gate classification and nearest-point offsets.
    tgod_offsets u_offsets (
        .i_item (r_item),
        .o_span (w_span)
    );

    // Straight steps in Q.8 plus the surcharge for each diagonal step.
    assign w_prod = {{C{1'b0}}, r_diag_extra}
                  * {{tgod_pkg::DIAG_EXTRA_W{1'b0}}, r_span.small_mag};
    assign w_sum  = (CALC_W'(r_span.big) << tgod_pkg::FRAC_BITS) + CALC_W'(w_prod);
    assign n_dist = (w_sum > CALC_W'(tgod_pkg::DIST_MAX))
                  ? tgod_pkg::DIST_MAX : w_sum[tgod_pkg::DIST_W-1:0];

`ifndef SYNTHESIS
    // The result stage is never valid right after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A surcharge write lands in the register on the next cycle.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> r_diag_extra == $past(i_cfg_data))
        else $error("surcharge write lost");

    // The geometry stage always orders the two magnitudes.
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> r_span.small_mag <= r_span.big)
        else $error("offset magnitudes out of order");

    // A tile on the gate gives a zero distance, and the result advances.
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && w_rdy3 && r_span.big == '0 |=> r_v3 && r_dist == '0)
        else $error("nonzero distance for zero offsets");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;

    // Generous bound: every request waiting out the longest sender gap and the
    // longest receiver stall, plus the drains around each surcharge change.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PIPE_DEPTH  = 3;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 216;

    typedef enum int {
        GATE_SINGLE,
        GATE_VERTICAL,
        GATE_HORIZONTAL,
        GATE_DIAGONAL,
        GATE_IRREGULAR,
        GATE_KINDS
    } t_gate_kind;

    // Reference predictor and queue of distances still owed by the block.
    class t_octile_scoreboard;
        logic [tgod_pkg::DIAG_EXTRA_W-1:0] extra;
        logic [tgod_pkg::DIST_W-1:0]       pending_dist[$];
        int                                errors;
        int                                checked;
        int                                kind_count[GATE_KINDS];

        function new();
            extra   = tgod_pkg::DIAG_EXTRA_RESET;
            errors  = 0;
            checked = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function t_gate_kind classify(tgod_pkg::t_item it);
            int wx;
            int wy;
            wx = int'(it.gate_end_x) - int'(it.gate_start_x);
            wy = int'(it.gate_end_y) - int'(it.gate_start_y);
            if (wx == 0 && wy == 0) return GATE_SINGLE;
            if (wx == 0) return GATE_VERTICAL;
            if (wy == 0) return GATE_HORIZONTAL;
            if (wx == wy || wx == -wy) return GATE_DIAGONAL;
            return GATE_IRREGULAR;
        endfunction

        // Offsets to the nearest part of the gate, then the octile cost in Q.8.
        function logic [tgod_pkg::DIST_W-1:0] predict_distance(tgod_pkg::t_item it);
            int     tx, ty, sx, sy, ex, ey;
            int     lx, hx, ly, hy;
            int     dx, dy;
            bit     backslash;
            longint ax, ay, big_mag, small_mag, dist_q8;
            tx = int'(it.tile_x);
            ty = int'(it.tile_y);
            sx = int'(it.gate_start_x);
            sy = int'(it.gate_start_y);
            ex = int'(it.gate_end_x);
            ey = int'(it.gate_end_y);
            lx = (sx < ex) ? sx : ex;
            hx = (sx < ex) ? ex : sx;
            ly = (sy < ey) ? sy : ey;
            hy = (sy < ey) ? ey : sy;
            dx = 0;
            dy = 0;
            if (sx == ex) begin
                // Vertical, and a single-tile gate falls in here as well.
                if (ty > hy) dy = ty - hy;
                else if (ty < ly) dy = ly - ty;
                dx = tx - sx;
            end else if (sy == ey) begin
                if (tx > hx) dx = tx - hx;
                else if (tx < lx) dx = lx - tx;
                dy = ty - sy;
            end else begin
                backslash = (sy > ey) ? (sx <= ex) : (sx > ex);
                if (backslash) begin
                    if (ty > hy - (lx - tx)) begin
                        dx = tx - lx;
                        dy = ty - hy;
                    end else if (ty < ly - (hx - tx)) begin
                        dx = hx - tx;
                        dy = ly - ty;
                    end else begin
                        // Signed division truncates toward zero, as intended.
                        dx = ((tx - lx) + (tx - hx) + (ty - ly) + (ty - hy)) / 4;
                        dy = dx;
                    end
                end else begin
                    if (ty > hy - (tx - hx)) begin
                        dx = tx - hx;
                        dy = ty - hy;
                    end else if (ty < ly - (tx - lx)) begin
                        dx = lx - tx;
                        dy = ly - ty;
                    end else begin
                        dx = ((tx - lx) + (tx - hx) + (ly - ty) + (hy - ty)) / 4;
                        dy = dx;
                    end
                end
            end
            ax        = (dx < 0) ? -dx : dx;
            ay        = (dy < 0) ? -dy : dy;
            big_mag   = (ax > ay) ? ax : ay;
            small_mag = (ax > ay) ? ay : ax;
            dist_q8   = (big_mag << tgod_pkg::FRAC_BITS) + longint'(extra) * small_mag;
            if (dist_q8 > longint'(tgod_pkg::DIST_MAX)) dist_q8 = longint'(tgod_pkg::DIST_MAX);
            return dist_q8[tgod_pkg::DIST_W-1:0];
        endfunction

        function void note_request(tgod_pkg::t_item it);
            pending_dist = {pending_dist, predict_distance(it)};
            kind_count[classify(it)]++;
        endfunction

        function void check_result(logic [tgod_pkg::DIST_W-1:0] got);
            logic [tgod_pkg::DIST_W-1:0] want;
            if (pending_dist.size() == 0) begin
                $error("distance: unexpected result, expected none, actual %0d", got);
                errors++;
                return;
            end
            want = pending_dist.pop_front();
            checked++;
            if (got !== want) begin
                $error("distance: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    wire                                 s_axis_tready;
    logic [tgod_pkg::S_TDATA_W-1:0]      s_axis_tdata = '0;
    wire                                 m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    wire  [tgod_pkg::M_TDATA_W-1:0]      m_axis_tdata;
    logic                                i_cfg_valid = 1'b0;
    wire                                 o_cfg_ready;
    logic [tgod_pkg::DIAG_EXTRA_W-1:0]   i_cfg_data = '0;

    t_octile_scoreboard sb = new();
    int                 cycle_count = 0;
    bit                 tx_burst = 1'b0;
    bit                 rx_burst = 1'b0;
    int                 settings_used = 1;

    tile_to_gate_octile_distance i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Every result accepted on the master side is checked against the oldest
    // outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[tgod_pkg::DIST_W-1:0]);
        end
    end

    // Receiver: for every result it draws a stall length, holds tready low for
    // that many cycles, then waits for the result to be taken. Now and then it
    // switches into a burst mode where it never stalls.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 49) == 0) rx_burst = ($urandom_range(0, 2) == 0);
            stall = rx_burst ? 0 : int'($urandom_range(0, 17));
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // tdata from bit 0 up: tile_x, tile_y, gate_start_x, gate_start_y,
    // gate_end_x, gate_end_y.
    function automatic logic [tgod_pkg::S_TDATA_W-1:0] pack_request(tgod_pkg::t_item it);
        logic [tgod_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[6*tgod_pkg::COORD_BITS-1:0] = {it.gate_end_y, it.gate_end_x,
                                            it.gate_start_y, it.gate_start_x,
                                            it.tile_y, it.tile_x};
        return word;
    endfunction

    function automatic tgod_pkg::t_coord clamp_coord(int v);
        if (v < 0) return '0;
        if (v > (1 << tgod_pkg::COORD_BITS) - 1) return '1;
        return tgod_pkg::t_coord'(v);
    endfunction

    function automatic tgod_pkg::t_coord random_coord(int top);
        return tgod_pkg::t_coord'($urandom_range(0, top));
    endfunction

    // Random request: mostly well-formed gates of each kind, with the tile
    // often dropped near the gate so that all three diagonal regions are hit.
    function automatic tgod_pkg::t_item random_request();
        tgod_pkg::t_item it;
        t_gate_kind      kind;
        int              pick, lx, ly, len, span_x, span_y, top;
        bit              flip;
        top  = (1 << tgod_pkg::COORD_BITS) - 1;
        pick = int'($urandom_range(0, 9));
        kind = (pick < 1) ? GATE_SINGLE :
               (pick < 3) ? GATE_VERTICAL :
               (pick < 5) ? GATE_HORIZONTAL :
               (pick < 8) ? GATE_DIAGONAL : GATE_IRREGULAR;
        it.gate_start_x = random_coord(top);
        it.gate_start_y = random_coord(top);
        it.gate_end_x   = random_coord(top);
        it.gate_end_y   = random_coord(top);
        case (kind)
            GATE_SINGLE: begin
                it.gate_end_x = it.gate_start_x;
                it.gate_end_y = it.gate_start_y;
            end
            GATE_VERTICAL:   it.gate_end_x = it.gate_start_x;
            GATE_HORIZONTAL: it.gate_end_y = it.gate_start_y;
            GATE_DIAGONAL: begin
                lx  = int'($urandom_range(0, top - 1));
                ly  = int'($urandom_range(0, top - 1));
                len = (lx > ly) ? top - lx : top - ly;
                if ($urandom_range(0, 1) == 0 && len > 8) len = 8;
                len  = int'($urandom_range(1, len));
                flip = ($urandom_range(0, 1) == 1);
                it.gate_start_x = tgod_pkg::t_coord'(lx);
                it.gate_end_x   = tgod_pkg::t_coord'(lx + len);
                if ($urandom_range(0, 1) == 0) begin
                    // Slash: y rises with x.
                    it.gate_start_y = tgod_pkg::t_coord'(ly);
                    it.gate_end_y   = tgod_pkg::t_coord'(ly + len);
                end else begin
                    it.gate_start_y = tgod_pkg::t_coord'(ly + len);
                    it.gate_end_y   = tgod_pkg::t_coord'(ly);
                end
                if (flip) begin
                    {it.gate_start_x, it.gate_end_x} = {it.gate_end_x, it.gate_start_x};
                    {it.gate_start_y, it.gate_end_y} = {it.gate_end_y, it.gate_start_y};
                end
            end
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0) begin
            lx     = (it.gate_start_x < it.gate_end_x) ? int'(it.gate_start_x)
                                                       : int'(it.gate_end_x);
            ly     = (it.gate_start_y < it.gate_end_y) ? int'(it.gate_start_y)
                                                       : int'(it.gate_end_y);
            span_x = int'(it.gate_start_x) + int'(it.gate_end_x) - 2 * lx;
            span_y = int'(it.gate_start_y) + int'(it.gate_end_y) - 2 * ly;
            it.tile_x = clamp_coord(lx + int'($urandom_range(0, span_x))
                                    + int'($urandom_range(0, 80)) - 40);
            it.tile_y = clamp_coord(ly + int'($urandom_range(0, span_y))
                                    + int'($urandom_range(0, 80)) - 40);
        end else begin
            it.tile_x = random_coord(top);
            it.tile_y = random_coord(top);
        end
        return it;
    endfunction

    // One request on the slave stream, preceded by a random gap.
    task automatic send_request(input tgod_pkg::t_item it);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = ($urandom_range(0, 2) == 0);
        gap = tx_burst ? 0 : int'($urandom_range(0, 17));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= pack_request(it);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(it);
    endtask

    task automatic send_gate(input int tx, input int ty, input int sx, input int sy,
                             input int ex, input int ey);
        tgod_pkg::t_item it;
        it.tile_x       = tgod_pkg::t_coord'(tx);
        it.tile_y       = tgod_pkg::t_coord'(ty);
        it.gate_start_x = tgod_pkg::t_coord'(sx);
        it.gate_start_y = tgod_pkg::t_coord'(sy);
        it.gate_end_x   = tgod_pkg::t_coord'(ex);
        it.gate_end_y   = tgod_pkg::t_coord'(ey);
        send_request(it);
    endtask

    // Stop sending, wait for every owed result, then let the pipeline settle.
    task automatic wait_idle(input int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_dist.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_extra(input logic [tgod_pkg::DIAG_EXTRA_W-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.extra = value;
        settings_used++;
    endtask

    initial begin
        logic [tgod_pkg::DIAG_EXTRA_W-1:0] extra_value;
        int                                top;
        top = (1 << tgod_pkg::COORD_BITS) - 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run at the reset surcharge. Coordinate extremes first.
        send_gate(0, 0, 0, 0, 0, 0);
        send_gate(top, top, top, top, top, top);
        send_gate(0, 0, top, top, top, top);
        send_gate(top, 0, 0, top, 0, top);
        // Vertical gate: tile beside the span, above it (ends reversed), below it.
        send_gate(90, 120, 100, 50, 100, 200);
        send_gate(130, 300, 100, 200, 100, 50);
        send_gate(100, 10, 100, 50, 100, 200);
        // Horizontal gate: tile over the span, right of it, left of it.
        send_gate(600, 480, 300, 500, 900, 500);
        send_gate(1000, 700, 900, 500, 300, 500);
        send_gate(0, top, 300, 500, 900, 500);
        // Slash gate: upper end, lower end, middle, middle with a negative
        // sum that is not a multiple of four.
        send_gate(250, 260, 100, 100, 200, 200);
        send_gate(50, 40, 200, 200, 100, 100);
        send_gate(160, 120, 100, 100, 200, 200);
        send_gate(141, 150, 100, 100, 200, 200);
        // Backslash gate: both end regions, middle with reversed ends, and a
        // middle point whose average truncates toward zero.
        send_gate(50, 260, 100, 200, 200, 100);
        send_gate(260, 50, 100, 200, 200, 100);
        send_gate(150, 160, 200, 100, 100, 200);
        send_gate(140, 141, 100, 200, 200, 100);
        // Gates that are neither axis-aligned nor at 45 degrees.
        send_gate(2000, 3000, 0, 0, top, 1);
        send_gate(top, top, 10, 10, 12, top - 95);
        // Full-grid diagonals.
        send_gate(top, 0, 0, 0, top, top);
        send_gate(0, 0, 0, top, top, 0);

        // Random phases, each under its own surcharge, extremes included.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       extra_value = '0;
                1:       extra_value = '1;
                2:       extra_value = tgod_pkg::DIAG_EXTRA_W'(1);
                3:       extra_value = tgod_pkg::DIAG_EXTRA_RESET;
                default: extra_value = tgod_pkg::DIAG_EXTRA_W'(
                             $urandom_range(0, (1 << tgod_pkg::DIAG_EXTRA_W) - 1));
            endcase
            wait_idle(PIPE_DEPTH + 1);
            write_extra(extra_value);
            // The far corner gives the largest distance the setting allows.
            send_gate(0, 0, top, top, top, top);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 149) == 0) wait_idle(0);
                send_request(random_request());
            end
        end

        wait_idle(PIPE_DEPTH + 8);
        $display("Checked %0d distances under %0d surcharge settings.",
                 sb.checked, settings_used);
        $display("Gates: %0d single, %0d vertical, %0d horizontal, %0d 45-degree, %0d other.",
                 sb.kind_count[GATE_SINGLE], sb.kind_count[GATE_VERTICAL],
                 sb.kind_count[GATE_HORIZONTAL], sb.kind_count[GATE_DIAGONAL],
                 sb.kind_count[GATE_IRREGULAR]);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/tgod_pkg.sv
sv/tgod_offsets.sv
sv/tile_to_gate_octile_distance.sv
dv/tb_top.sv
